// ----- hdl/eepx_pkg.sv -----
// ----------------------------------------------------------------------------
// eepx_pkg
// Shared constants for the edge-edge proximity test.
// ----------------------------------------------------------------------------
package eepx_pkg;

  // packed point field and radius widths
  localparam int FIELD_W   = 63;
  localparam int RADIUS_W  = 20;
  // radius_i + radius_j + margin
  localparam int SUM_W     = RADIUS_W + 2;
  // bits of the multiplier operand consumed per pipeline stage
  localparam int MUL_DIGIT = 16;

endpackage

// ----- hdl/eepx_if.sv -----
// ----------------------------------------------------------------------------
// eepx_in_if / eepx_out_if
// Valid/ready channels for pair requests and proximity results.
// ----------------------------------------------------------------------------
interface eepx_in_if;
  logic                            valid;
  logic                            ready;
  logic [eepx_pkg::FIELD_W-1:0]    edge_i_start;
  logic [eepx_pkg::FIELD_W-1:0]    edge_i_end;
  logic [eepx_pkg::FIELD_W-1:0]    edge_j_start;
  logic [eepx_pkg::FIELD_W-1:0]    edge_j_end;
  logic [eepx_pkg::RADIUS_W-1:0]   radius_i;
  logic [eepx_pkg::RADIUS_W-1:0]   radius_j;

  modport source (
    output valid, edge_i_start, edge_i_end, edge_j_start, edge_j_end, radius_i, radius_j,
    input  ready
  );
  modport sink (
    input  valid, edge_i_start, edge_i_end, edge_j_start, edge_j_end, radius_i, radius_j,
    output ready
  );
endinterface

interface eepx_out_if;
  logic valid;
  logic ready;
  logic near;

  modport source (output valid, near, input ready);
  modport sink   (input valid, near, output ready);
endinterface

// ----- hdl/edge_edge_proximity_test_core.sv -----
// ----------------------------------------------------------------------------
// edge_edge_proximity_test_core
// Exact fixed-point closest-approach test of two 3D segments.
// ----------------------------------------------------------------------------
// One pair request enters per clock unless the result side stalls, and each
// yields one result. The latency is set by the digit-serial squaring
// of the gap vector, which walks the 117-bit operand 16 bits per stage.
// Back-pressure on the result side stalls the whole pipeline in place.
// reach_margin may only be written while no request is in flight.
module edge_edge_proximity_test_core #(
  parameter int COORD_BITS = 21
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [eepx_pkg::RADIUS_W-1:0] cfg_wr_data,
  eepx_in_if.sink                       in_req,
  eepx_out_if.source                    out_res
);

  localparam int DIG   = eepx_pkg::MUL_DIGIT;
  localparam int SUMW  = eepx_pkg::SUM_W;
  localparam int DW    = COORD_BITS + 1;
  localparam int PW    = 2 * DW;
  localparam int DOTW  = PW + 2;
  localparam int P2W   = 2 * DOTW;
  localparam int FW    = P2W + 1;
  localparam int GPW   = FW + DW;
  localparam int XW    = GPW + 2;
  localparam int SQW   = 2 * XW;
  localparam int ACCW  = SQW + 2;
  localparam int FFW   = 2 * FW;
  localparam int S2W   = 2 * (SUMW + 1);
  localparam int RHSW  = FFW + S2W;

  localparam int L_DOT = (DOTW + DIG - 1) / DIG;
  localparam int L_G   = (DW + DIG - 1) / DIG;
  localparam int L_SQ  = (XW + DIG - 1) / DIG;
  localparam int L_FF  = (FW + DIG - 1) / DIG;
  localparam int L_RHS = (S2W + DIG - 1) / DIG;

  localparam int T_F   = 3 + L_DOT + 1;
  localparam int T_ACC = T_F + L_G + 1 + L_SQ + 1;
  localparam int T_RHS = T_F + L_FF + L_RHS;
  localparam int LAT   = T_ACC + 1;

  logic                en;
  logic [LAT-1:0]      vld;
  logic [eepx_pkg::RADIUS_W-1:0] reach_margin;

  assign en           = !out_res.valid || out_res.ready;
  assign in_req.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      reach_margin <= '0;
    end else if (cfg_wr_en) begin
      reach_margin <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_req.valid};
    end
  end

  // stage 1: edge vectors, offset and reach sum
  logic [2:0][DW-1:0] ei, ej, v;
  logic [SUMW-1:0]    sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ei[k] <= DW'($signed(in_req.edge_i_end[k*COORD_BITS +: COORD_BITS]))
               - DW'($signed(in_req.edge_i_start[k*COORD_BITS +: COORD_BITS]));
        ej[k] <= DW'($signed(in_req.edge_j_end[k*COORD_BITS +: COORD_BITS]))
               - DW'($signed(in_req.edge_j_start[k*COORD_BITS +: COORD_BITS]));
        v[k]  <= DW'($signed(in_req.edge_i_start[k*COORD_BITS +: COORD_BITS]))
               - DW'($signed(in_req.edge_j_start[k*COORD_BITS +: COORD_BITS]));
      end
      sum_r <= SUMW'(in_req.radius_i) + SUMW'(in_req.radius_j) + SUMW'(reach_margin);
    end
  end

  // stage 2: component products
  logic signed [PW-1:0]  pcc [3];
  logic signed [PW-1:0]  pdd [3];
  logic signed [PW-1:0]  pee [3];
  logic signed [PW-1:0]  paa [3];
  logic signed [PW-1:0]  pbb [3];
  logic signed [S2W-1:0] sum2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pcc[k] <= $signed(ei[k]) * $signed(ei[k]);
        pdd[k] <= $signed(ej[k]) * $signed(ej[k]);
        pee[k] <= $signed(ei[k]) * $signed(ej[k]);
        paa[k] <= $signed(ei[k]) * $signed(v[k]);
        pbb[k] <= $signed(ej[k]) * $signed(v[k]);
      end
      sum2 <= $signed({1'b0, sum_r}) * $signed({1'b0, sum_r});
    end
  end

  // stage 3: dot products
  logic signed [DOTW-1:0] dc, dd, de, da, db;

  always_ff @(posedge clk) begin
    if (en) begin
      dc <= DOTW'(pcc[0]) + DOTW'(pcc[1]) + DOTW'(pcc[2]);
      dd <= DOTW'(pdd[0]) + DOTW'(pdd[1]) + DOTW'(pdd[2]);
      de <= DOTW'(pee[0]) + DOTW'(pee[1]) + DOTW'(pee[2]);
      da <= DOTW'(paa[0]) + DOTW'(paa[1]) + DOTW'(paa[2]);
      db <= DOTW'(pbb[0]) + DOTW'(pbb[1]) + DOTW'(pbb[2]);
    end
  end

  // determinant and numerators
  logic signed [P2W-1:0] m_cd, m_ee, m_eb, m_ad, m_cb, m_ea;

  eepx_mul #(.AW(DOTW), .BW(DOTW), .DIG(DIG)) u_mul_cd (
    .clk(clk), .en(en), .a(dc), .b(dd), .p(m_cd));
  eepx_mul #(.AW(DOTW), .BW(DOTW), .DIG(DIG)) u_mul_ee (
    .clk(clk), .en(en), .a(de), .b(de), .p(m_ee));
  eepx_mul #(.AW(DOTW), .BW(DOTW), .DIG(DIG)) u_mul_eb (
    .clk(clk), .en(en), .a(de), .b(db), .p(m_eb));
  eepx_mul #(.AW(DOTW), .BW(DOTW), .DIG(DIG)) u_mul_ad (
    .clk(clk), .en(en), .a(da), .b(dd), .p(m_ad));
  eepx_mul #(.AW(DOTW), .BW(DOTW), .DIG(DIG)) u_mul_cb (
    .clk(clk), .en(en), .a(dc), .b(db), .p(m_cb));
  eepx_mul #(.AW(DOTW), .BW(DOTW), .DIG(DIG)) u_mul_ea (
    .clk(clk), .en(en), .a(de), .b(da), .p(m_ea));

  logic signed [FW-1:0] f, sn, tn;

  always_ff @(posedge clk) begin
    if (en) begin
      f  <= FW'(m_cd) - FW'(m_ee);
      sn <= FW'(m_eb) - FW'(m_ad);
      tn <= FW'(m_cb) - FW'(m_ea);
    end
  end

  // both parameters inside [0,1] and lines not parallel
  logic in_range;

  always_ff @(posedge clk) begin
    if (en) begin
      in_range <= (f != '0) && !sn[FW-1] && (sn <= f) && !tn[FW-1] && (tn <= f);
    end
  end

  logic in_range_q;

  eepx_dly #(.W(1), .N(T_ACC - T_F - 1)) u_dly_flag (
    .clk(clk), .en(en), .d(in_range), .q(in_range_q));

  // edge and offset vectors realigned with f, sn, tn
  logic [2:0][DW-1:0] ei_q, ej_q, v_q;

  eepx_dly #(.W(3*DW), .N(T_F - 1)) u_dly_ei (.clk(clk), .en(en), .d(ei), .q(ei_q));
  eepx_dly #(.W(3*DW), .N(T_F - 1)) u_dly_ej (.clk(clk), .en(en), .d(ej), .q(ej_q));
  eepx_dly #(.W(3*DW), .N(T_F - 1)) u_dly_v  (.clk(clk), .en(en), .d(v),  .q(v_q));

  // scaled gap vector f*v + sn*ei - tn*ej
  logic signed [XW-1:0] gx [3];

  for (genvar k = 0; k < 3; k++) begin : g_gap
    logic signed [GPW-1:0] g_fv, g_se, g_tj;

    eepx_mul #(.AW(FW), .BW(DW), .DIG(DIG)) u_mul_fv (
      .clk(clk), .en(en), .a(f), .b($signed(v_q[k])), .p(g_fv));
    eepx_mul #(.AW(FW), .BW(DW), .DIG(DIG)) u_mul_se (
      .clk(clk), .en(en), .a(sn), .b($signed(ei_q[k])), .p(g_se));
    eepx_mul #(.AW(FW), .BW(DW), .DIG(DIG)) u_mul_tj (
      .clk(clk), .en(en), .a(tn), .b($signed(ej_q[k])), .p(g_tj));

    always_ff @(posedge clk) begin
      if (en) begin
        gx[k] <= XW'(g_fv) + XW'(g_se) - XW'(g_tj);
      end
    end
  end

  logic signed [SQW-1:0] gsq [3];

  for (genvar k = 0; k < 3; k++) begin : g_sq
    eepx_mul #(.AW(XW), .BW(XW), .DIG(DIG)) u_mul_sq (
      .clk(clk), .en(en), .a(gx[k]), .b(gx[k]), .p(gsq[k]));
  end

  logic signed [ACCW-1:0] acc;

  always_ff @(posedge clk) begin
    if (en) begin
      acc <= ACCW'(gsq[0]) + ACCW'(gsq[1]) + ACCW'(gsq[2]);
    end
  end

  // reach bound (sum * f)^2
  logic signed [FFW-1:0]  ff;
  logic [S2W-1:0]         sum2_q;
  logic signed [RHSW-1:0] rhs;
  logic [RHSW-1:0]        rhs_q;

  eepx_mul #(.AW(FW), .BW(FW), .DIG(DIG)) u_mul_ff (
    .clk(clk), .en(en), .a(f), .b(f), .p(ff));

  eepx_dly #(.W(S2W), .N(T_F + L_FF - 2)) u_dly_sum2 (
    .clk(clk), .en(en), .d(sum2), .q(sum2_q));

  eepx_mul #(.AW(FFW), .BW(S2W), .DIG(DIG)) u_mul_rhs (
    .clk(clk), .en(en), .a(ff), .b($signed(sum2_q)), .p(rhs));

  eepx_dly #(.W(RHSW), .N(T_ACC - T_RHS)) u_dly_rhs (
    .clk(clk), .en(en), .d(rhs), .q(rhs_q));

  // output register
  logic near_r;

  always_ff @(posedge clk) begin
    if (en) begin
      near_r <= in_range_q && (acc <= $signed(rhs_q));
    end
  end

  assign out_res.valid = vld[LAT-1];
  assign out_res.near  = near_r;

  // out of range or parallel never reports near
  a_flag_gates_near: assert property (@(posedge clk) disable iff (rst)
    en && vld[LAT-2] && !in_range_q |=> !near_r)
    else $error("near raised for a pair outside the segments");

  // a stall freezes every valid bit
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid bits moved during a stall");

  // input side only blocked by a waiting result
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    !in_req.ready |-> out_res.valid && !out_res.ready)
    else $error("input blocked without result back-pressure");

  // pipeline empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_res.valid)
    else $error("result valid straight after reset");

endmodule

// ----- hdl/eepx_dly.sv -----
// ----------------------------------------------------------------------------
// eepx_dly
// Enabled shift line that keeps side data aligned with the datapath.
// ----------------------------------------------------------------------------
module eepx_dly #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  if (N == 0) begin : g_pass
    assign q = d;
  end else begin : g_line
    logic [W-1:0] sr [N];
    always_ff @(posedge clk) begin
      if (en) begin
        sr[0] <= d;
        for (int i = 1; i < N; i++) begin
          sr[i] <= sr[i-1];
        end
      end
    end
    assign q = sr[N-1];
  end

endmodule

// ----- hdl/eepx_mul.sv -----
// ----------------------------------------------------------------------------
// eepx_mul
// Pipelined signed multiplier, one DIG-bit digit of b per stage.
// ----------------------------------------------------------------------------
module eepx_mul #(
  parameter int AW  = 16,
  parameter int BW  = 16,
  parameter int DIG = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int ND  = (BW + DIG - 1) / DIG;
  localparam int BPW = ND * DIG;
  localparam int PW  = AW + BW;

  logic signed [BPW-1:0] b_ext;
  logic signed [AW-1:0]  a_pipe [ND];
  logic signed [BPW-1:0] b_pipe [ND];
  logic signed [PW-1:0]  acc    [ND];

  assign b_ext = BPW'(b);

  for (genvar k = 0; k < ND; k++) begin : g_stage
    logic signed [AW-1:0]  a_src;
    logic signed [BPW-1:0] b_src;
    logic signed [PW-1:0]  acc_src;
    logic [DIG-1:0]        dig;
    logic signed [DIG:0]   dig_s;
    logic signed [AW+DIG:0] pp;

    if (k == 0) begin : g_first
      assign a_src   = a;
      assign b_src   = b_ext;
      assign acc_src = '0;
    end else begin : g_next
      assign a_src   = a_pipe[k-1];
      assign b_src   = b_pipe[k-1];
      assign acc_src = acc[k-1];
    end

    assign dig = b_src[k*DIG +: DIG];
    // top digit carries the sign of b
    if (k == ND - 1) begin : g_top
      assign dig_s = {dig[DIG-1], dig};
    end else begin : g_low
      assign dig_s = {1'b0, dig};
    end

    assign pp = a_src * dig_s;

    always_ff @(posedge clk) begin
      if (en) begin
        acc[k] <= acc_src + (PW'(pp) <<< (k * DIG));
      end
    end

    if (k < ND - 1) begin : g_pipe
      always_ff @(posedge clk) begin
        if (en) begin
          a_pipe[k] <= a_src;
          b_pipe[k] <= b_src;
        end
      end
    end
  end

  assign p = acc[ND-1];

endmodule
